// File: rtl/sfs_pkg.sv
// shared types, constants and the crc-32 byte step for the scope frame serializer
package sfs_pkg;

    // frame format constants
    localparam logic [31:0] MAGIC_WORD     = 32'h1234_5678;
    localparam logic [7:0]  FORMAT_VERSION = 8'd1;

    // reflected crc-32
    localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;
    localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;

    // default depth of the command queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // configuration register indexes
    localparam logic [2:0] CFG_DECIMATION      = 3'd0;
    localparam logic [2:0] CFG_PRETRIGGER_LEN  = 3'd1;
    localparam logic [2:0] CFG_POSTTRIGGER_LEN = 3'd2;
    localparam logic [2:0] CFG_TRIGGER_LEVEL   = 3'd3;
    localparam logic [2:0] CFG_FRONT_ATTEN     = 3'd4;
    localparam logic [2:0] CFG_FRONT_FLAGS     = 3'd5;
    localparam logic [2:0] CFG_AMP_ATTEN       = 3'd6;
    localparam logic [2:0] CFG_OFFSET_DAC_CODE = 3'd7;

    // result kind carried on the output tuser
    typedef enum logic [1:0] {
        ST_DATA  = 2'd0,
        ST_ZERO  = 2'd1,
        ST_ABORT = 2'd2
    } status_t;

    // one classified transaction handed from front to back
    typedef struct packed {
        logic        abort;     // abort marker for the frame left open
        logic        zero;      // zero-count error marker
        logic        header;    // emit the 36-byte header
        logic        column;    // emit the four column bytes
        logic        trailer;   // emit the crc after the column
        logic [15:0] column_count;
        logic [7:0]  frame_flags;
        logic [31:0] sequence_num;
        logic [31:0] sample_total;
        logic [31:0] trigger_index;
        logic [15:0] overrange_total;
        logic [15:0] low_value;
        logic [15:0] high_value;
    } cmd_t;

    // feed one byte into the reflected crc
    function automatic logic [31:0] crc32_byte(logic [31:0] crc, logic [7:0] data);
        logic [31:0] c;
        c = crc ^ {24'd0, data};
        for (int b = 0; b < 8; b++)
        begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

// File: rtl/scope_frame_serializer_crc32_core.sv
// top level of the scope frame serializer with crc-32 trailer
// an accepted command goes into the command queue, from which an idle back end loads its first byte
// into the output register; while m_tready holds, one output byte per cycle: a column gives 4 bytes
//   (8 when it closes the frame), a start 40 (44 with its trailer), a marker 1, an ignored column 0
// input is taken while the command queue has room, so the front runs ahead of the output
// reset: asynchronous active-low rst_n clears queue, frame tracking and config, crc to all ones
module scope_frame_serializer_crc32_core #(
    parameter int QUEUE_DEPTH = sfs_pkg::QUEUE_DEPTH
) (
    input  logic         clk,
    input  logic         rst_n,
    // tdata: column_count, frame_flags, sequence_num, sample_total, trigger_index,
    //        overrange_total, low_value, high_value
    input  logic [167:0] s_tdata,
    // tuser: frame_start
    input  logic [0:0]   s_tuser,
    input  logic         s_tvalid,
    output logic         s_tready,
    // tdata: data_byte
    output logic [7:0]   m_tdata,
    // tuser: status
    output logic [1:0]   m_tuser,
    output logic         m_tlast,
    output logic         m_tvalid,
    input  logic         m_tready,
    input  logic         cfg_we,
    input  logic [2:0]   cfg_index,
    input  logic [15:0]  cfg_wdata
);

    sfs_pkg::cmd_t push_cmd;
    sfs_pkg::cmd_t head_cmd;
    logic          q_push;
    logic          q_full;
    logic          q_pop;
    logic          q_empty;

    // classify input transactions
    sfs_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_cmd    (push_cmd)
    );

    // decoupling queue
    sfs_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .head_cmd (head_cmd),
        .empty    (q_empty)
    );

    // byte serializer
    sfs_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .head_cmd  (head_cmd),
        .q_empty   (q_empty),
        .q_pop     (q_pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

`ifndef SYNTH
    // the front never pushes into a full queue
    assert property (@(posedge clk) disable iff (!rst_n) q_push |-> !q_full)
        else $error("command pushed into full queue");

    // retiring a command always leaves its final byte in the output register
    assert property (@(posedge clk) disable iff (!rst_n) q_pop |=> m_tvalid)
        else $error("command retired without output byte");

    // marker results end the frame and carry a zero byte
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser != sfs_pkg::ST_DATA) |-> (m_tlast && m_tdata == 8'd0))
        else $error("marker result malformed");
`endif

endmodule

// File: rtl/sfs_front.sv
// front end: accepts input transactions, tracks the open frame and builds commands
module sfs_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [167:0]       s_tdata,
    input  logic [0:0]         s_tuser,
    input  logic               q_full,
    output logic               q_push,
    output sfs_pkg::cmd_t      q_cmd
);

    logic        frame_open_reg, frame_open_next;
    logic [15:0] columns_left_reg, columns_left_next;
    logic        accept;
    logic        start;
    logic [15:0] count;
    logic [15:0] left_minus_one;
    logic [15:0] count_minus_one;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;
    assign start    = s_tuser[0];
    assign count    = s_tdata[15:0];

    assign left_minus_one  = columns_left_reg - 16'd1;
    assign count_minus_one = count - 16'd1;

    // classify the transaction and update frame tracking
    always_comb
    begin
        q_cmd                 = '0;
        q_cmd.column_count    = count;
        q_cmd.frame_flags     = s_tdata[23:16];
        q_cmd.sequence_num    = s_tdata[55:24];
        q_cmd.sample_total    = s_tdata[87:56];
        q_cmd.trigger_index   = s_tdata[119:88];
        q_cmd.overrange_total = s_tdata[135:120];
        q_cmd.low_value       = s_tdata[151:136];
        q_cmd.high_value      = s_tdata[167:152];
        q_push                = 1'b0;
        frame_open_next       = frame_open_reg;
        columns_left_next     = columns_left_reg;
        if (accept)
        begin
            if (start)
            begin
                q_push      = 1'b1;
                q_cmd.abort = frame_open_reg;
                if (count == 16'd0)
                begin
                    q_cmd.zero        = 1'b1;
                    frame_open_next   = 1'b0;
                    columns_left_next = 16'd0;
                end
                else
                begin
                    q_cmd.header      = 1'b1;
                    q_cmd.column      = 1'b1;
                    q_cmd.trailer     = (count_minus_one == 16'd0);
                    frame_open_next   = (count_minus_one != 16'd0);
                    columns_left_next = count_minus_one;
                end
            end
            else if (frame_open_reg)
            begin
                // a column with no open frame is dropped here
                q_push            = 1'b1;
                q_cmd.column      = 1'b1;
                q_cmd.trailer     = (left_minus_one == 16'd0);
                frame_open_next   = (left_minus_one != 16'd0);
                columns_left_next = left_minus_one;
            end
        end
    end

    // frame tracking state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_open_reg   <= 1'b0;
            columns_left_reg <= 16'd0;
        end
        else
        begin
            frame_open_reg   <= frame_open_next;
            columns_left_reg <= columns_left_next;
        end
    end

endmodule

// File: rtl/sfs_queue.sv
// short command queue between the front and back ends
module sfs_queue #(
    parameter int DEPTH = sfs_pkg::QUEUE_DEPTH
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  sfs_pkg::cmd_t push_cmd,
    output logic          full,
    input  logic          pop,
    output sfs_pkg::cmd_t head_cmd,
    output logic          empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    sfs_pkg::cmd_t  store_reg [DEPTH];
    logic [PW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]  count_reg, count_next;
    logic           do_push;
    logic           do_pop;

    assign full     = (count_reg == CW'(DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign head_cmd = store_reg[rd_ptr_reg];

    // pointer and fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            store_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// File: rtl/sfs_back.sv
// back end: walks each command byte by byte, keeps the crc and drives the output register
module sfs_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_we,
    input  logic [2:0]    cfg_index,
    input  logic [15:0]   cfg_wdata,
    input  sfs_pkg::cmd_t head_cmd,
    input  logic          q_empty,
    output logic          q_pop,
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [7:0]    m_tdata,
    output logic          m_tlast,
    output logic [1:0]    m_tuser
);

    // byte positions within one command
    localparam logic [5:0] POS_ABORT     = 6'd0;
    localparam logic [5:0] POS_ZERO      = 6'd1;
    localparam logic [5:0] POS_HDR_FIRST = 6'd2;
    localparam logic [5:0] POS_CRC_FIRST = 6'd6;
    localparam logic [5:0] POS_HDR_LAST  = 6'd37;
    localparam logic [5:0] POS_COL_FIRST = 6'd38;
    localparam logic [5:0] POS_COL_LAST  = 6'd41;
    localparam logic [5:0] POS_TRL_FIRST = 6'd42;
    localparam logic [5:0] POS_TRL_LAST  = 6'd45;
    localparam logic [5:0] POS_END       = 6'd46;

    logic [15:0] decimation_reg;
    logic [15:0] pretrigger_len_reg;
    logic [15:0] posttrigger_len_reg;
    logic [15:0] trigger_level_reg;
    logic [7:0]  front_atten_reg;
    logic [7:0]  front_flags_reg;
    logic [7:0]  amp_atten_reg;
    logic [15:0] offset_dac_code_reg;

    logic [31:0] crc_accum_reg;
    logic [5:0]  pos_reg;
    logic        m_tvalid_reg;
    logic [7:0]  m_tdata_reg;
    logic        m_tlast_reg;
    logic [1:0]  m_tuser_reg;

    logic         out_ready;
    logic         emit;
    logic [5:0]   cur;
    logic [5:0]   after;
    logic [5:0]   sel;
    logic         marker;
    logic [287:0] hdr_bits;
    logic [351:0] frame_bits;
    logic [7:0]   byte_next;
    logic         last_next;
    logic [1:0]   user_next;

    // first enabled byte position at or after q
    function automatic logic [5:0] first_from(logic [5:0] q, sfs_pkg::cmd_t c);
        logic [5:0] r;
        r = POS_END;
        if (c.trailer && q <= POS_TRL_LAST)
        begin
            r = (q > POS_TRL_FIRST) ? q : POS_TRL_FIRST;
        end
        if (c.column && q <= POS_COL_LAST)
        begin
            r = (q > POS_COL_FIRST) ? q : POS_COL_FIRST;
        end
        if (c.header && q <= POS_HDR_LAST)
        begin
            r = (q > POS_HDR_FIRST) ? q : POS_HDR_FIRST;
        end
        if (c.zero && q <= POS_ZERO)
        begin
            r = POS_ZERO;
        end
        if (c.abort && q == POS_ABORT)
        begin
            r = POS_ABORT;
        end
        return r;
    endfunction

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            decimation_reg      <= 16'd0;
            pretrigger_len_reg  <= 16'd0;
            posttrigger_len_reg <= 16'd0;
            trigger_level_reg   <= 16'd0;
            front_atten_reg     <= 8'd0;
            front_flags_reg     <= 8'd0;
            amp_atten_reg       <= 8'd0;
            offset_dac_code_reg <= 16'd0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                sfs_pkg::CFG_DECIMATION:      decimation_reg      <= cfg_wdata;
                sfs_pkg::CFG_PRETRIGGER_LEN:  pretrigger_len_reg  <= cfg_wdata;
                sfs_pkg::CFG_POSTTRIGGER_LEN: posttrigger_len_reg <= cfg_wdata;
                sfs_pkg::CFG_TRIGGER_LEVEL:   trigger_level_reg   <= cfg_wdata;
                sfs_pkg::CFG_FRONT_ATTEN:     front_atten_reg     <= cfg_wdata[7:0];
                sfs_pkg::CFG_FRONT_FLAGS:     front_flags_reg     <= cfg_wdata[7:0];
                sfs_pkg::CFG_AMP_ATTEN:       amp_atten_reg       <= cfg_wdata[7:0];
                sfs_pkg::CFG_OFFSET_DAC_CODE: offset_dac_code_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // sequencing over the byte positions of the head command
    assign out_ready = !m_tvalid_reg || m_tready;
    assign emit      = !q_empty && out_ready;
    assign cur       = first_from(pos_reg, head_cmd);
    assign after     = first_from(cur + 6'd1, head_cmd);
    assign q_pop     = emit && (after == POS_END);

    // frame bytes, first byte in the low bits
    assign hdr_bits = {offset_dac_code_reg, 8'h00, amp_atten_reg, front_flags_reg,
                       front_atten_reg, head_cmd.overrange_total, trigger_level_reg,
                       head_cmd.trigger_index, posttrigger_len_reg, pretrigger_len_reg,
                       decimation_reg, head_cmd.sample_total, head_cmd.sequence_num,
                       head_cmd.column_count, head_cmd.frame_flags,
                       sfs_pkg::FORMAT_VERSION, sfs_pkg::MAGIC_WORD};
    assign frame_bits = {~crc_accum_reg, head_cmd.high_value, head_cmd.low_value, hdr_bits};

    // byte select and result kind
    always_comb
    begin
        marker    = (cur == POS_ABORT) || (cur == POS_ZERO);
        sel       = marker ? 6'd0 : cur - POS_HDR_FIRST;
        byte_next = marker ? 8'd0 : frame_bits[{sel, 3'b000} +: 8];
        last_next = marker || (cur == POS_TRL_LAST);
        if (cur == POS_ABORT)
        begin
            user_next = sfs_pkg::ST_ABORT;
        end
        else if (cur == POS_ZERO)
        begin
            user_next = sfs_pkg::ST_ZERO;
        end
        else
        begin
            user_next = sfs_pkg::ST_DATA;
        end
    end

    // position, crc and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= POS_ABORT;
            crc_accum_reg <= sfs_pkg::CRC_INIT;
            m_tvalid_reg  <= 1'b0;
        end
        else
        begin
            if (emit)
            begin
                pos_reg      <= q_pop ? POS_ABORT : cur + 6'd1;
                m_tvalid_reg <= 1'b1;
                if (cur == POS_HDR_FIRST)
                begin
                    crc_accum_reg <= sfs_pkg::CRC_INIT;
                end
                else if (cur >= POS_CRC_FIRST && cur <= POS_COL_LAST)
                begin
                    crc_accum_reg <= sfs_pkg::crc32_byte(crc_accum_reg, byte_next);
                end
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            m_tdata_reg <= byte_next;
            m_tlast_reg <= last_next;
            m_tuser_reg <= user_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

// File: tb/scope_frame_checker.sv
// checker for the scope frame serializer: predicts the byte stream and compares output transactions
module scope_frame_checker (
    input  logic         clk,
    input  logic         rst_n,
    // tdata: column_count, frame_flags, sequence_num, sample_total, trigger_index,
    //        overrange_total, low_value, high_value
    input  logic [167:0] s_tdata,
    // tuser: frame_start
    input  logic [0:0]   s_tuser,
    input  logic         s_tvalid,
    input  logic         s_tready,
    // tdata: data_byte
    input  logic [7:0]   m_tdata,
    // tuser: status
    input  logic [1:0]   m_tuser,
    input  logic         m_tlast,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic         cfg_we,
    input  logic [2:0]   cfg_index,
    input  logic [15:0]  cfg_wdata,
    output int           fail_count,
    output int           pending_count,
    output int           frame_count,
    output int           marker_count,
    output int           byte_count
);

    // one predicted output transaction
    typedef struct packed {
        logic [7:0]       data_byte;
        logic             frame_done;
        sfs_pkg::status_t status;
    } frame_byte_t;

    frame_byte_t expected_bytes[$];

    // predictor state
    logic [31:0] crc_run;
    logic [15:0] cols_left;
    logic        in_frame;

    // copy of the acquisition settings
    logic [15:0] set_decimation;
    logic [15:0] set_pretrigger;
    logic [15:0] set_posttrigger;
    logic [15:0] set_trigger_level;
    logic [7:0]  set_front_atten;
    logic [7:0]  set_front_flags;
    logic [7:0]  set_amp_atten;
    logic [15:0] set_offset_dac;

    // one byte through the reflected crc, lsb first
    function automatic logic [31:0] crc_next(logic [31:0] c, logic [7:0] d);
        logic [31:0] r;
        int          k;
        r = c ^ {24'h0, d};
        for (k = 0; k < 8; k++)
        begin
            r = {1'b0, r[31:1]} ^ (r[0] ? sfs_pkg::CRC_POLY : 32'h0);
        end
        return r;
    endfunction

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        if (fail_count < 20)
            $display("mismatch @%0t: %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
        fail_count++;
    endtask

    task automatic push_byte(input logic [7:0] b, input logic done, input sfs_pkg::status_t st);
        frame_byte_t e;
        e.data_byte  = b;
        e.frame_done = done;
        e.status     = st;
        expected_bytes.push_back(e);
    endtask

    // little-endian bytes of a value, optionally covered by the crc
    task automatic push_le(input logic [31:0] value, input int nbytes, input logic feed);
        logic [7:0] b;
        int         i;
        for (i = 0; i < nbytes; i++)
        begin
            b = value[8*i +: 8];
            if (feed)
                crc_run = crc_next(crc_run, b);
            push_byte(b, 1'b0, sfs_pkg::ST_DATA);
        end
    endtask

    // four column bytes, then the inverted crc after the last counted column
    task automatic push_column(input logic [15:0] lo, input logic [15:0] hi);
        logic [31:0] crc_out;
        push_le({16'h0, lo}, 2, 1'b1);
        push_le({16'h0, hi}, 2, 1'b1);
        cols_left = cols_left - 16'd1;
        if (cols_left == 16'd0)
        begin
            crc_out = ~crc_run;
            push_le(crc_out, 3, 1'b0);
            push_byte(crc_out[31:24], 1'b1, sfs_pkg::ST_DATA);
            in_frame = 1'b0;
            crc_run  = sfs_pkg::CRC_INIT;
        end
    endtask

    // expected bytes for one accepted input transaction
    task automatic serialize_item(input logic start, input logic [167:0] d);
        logic [15:0] count;
        count = d[15:0];
        if (!start)
        begin
            if (in_frame)
                push_column(d[151:136], d[167:152]);
        end
        else
        begin
            // a start drops any open frame behind an abort marker
            if (in_frame)
            begin
                push_byte(8'h00, 1'b1, sfs_pkg::ST_ABORT);
                in_frame = 1'b0;
            end
            crc_run   = sfs_pkg::CRC_INIT;
            cols_left = 16'd0;
            if (count == 16'd0)
                push_byte(8'h00, 1'b1, sfs_pkg::ST_ZERO);
            else
            begin
                push_le(sfs_pkg::MAGIC_WORD, 4, 1'b0);
                push_le({24'h0, sfs_pkg::FORMAT_VERSION}, 1, 1'b1);
                push_le({24'h0, d[23:16]}, 1, 1'b1);
                push_le({16'h0, count}, 2, 1'b1);
                push_le(d[55:24], 4, 1'b1);
                push_le(d[87:56], 4, 1'b1);
                push_le({16'h0, set_decimation}, 2, 1'b1);
                push_le({16'h0, set_pretrigger}, 2, 1'b1);
                push_le({16'h0, set_posttrigger}, 2, 1'b1);
                push_le(d[119:88], 4, 1'b1);
                push_le({16'h0, set_trigger_level}, 2, 1'b1);
                push_le({16'h0, d[135:120]}, 2, 1'b1);
                push_le({24'h0, set_front_atten}, 1, 1'b1);
                push_le({24'h0, set_front_flags}, 1, 1'b1);
                push_le({24'h0, set_amp_atten}, 1, 1'b1);
                push_le(32'h0, 1, 1'b1);
                push_le({16'h0, set_offset_dac}, 2, 1'b1);
                cols_left = count;
                in_frame  = 1'b1;
                push_column(d[151:136], d[167:152]);
            end
        end
    endtask

    task automatic apply_setting(input logic [2:0] index, input logic [15:0] value);
        case (index)
            sfs_pkg::CFG_DECIMATION:      set_decimation    = value;
            sfs_pkg::CFG_PRETRIGGER_LEN:  set_pretrigger    = value;
            sfs_pkg::CFG_POSTTRIGGER_LEN: set_posttrigger   = value;
            sfs_pkg::CFG_TRIGGER_LEVEL:   set_trigger_level = value;
            sfs_pkg::CFG_FRONT_ATTEN:     set_front_atten   = value[7:0];
            sfs_pkg::CFG_FRONT_FLAGS:     set_front_flags   = value[7:0];
            sfs_pkg::CFG_AMP_ATTEN:       set_amp_atten     = value[7:0];
            sfs_pkg::CFG_OFFSET_DAC_CODE: set_offset_dac    = value;
            default:                      ;
        endcase
    endtask

    task automatic check_output();
        frame_byte_t want;
        if (expected_bytes.size() == 0)
            report("output transaction with nothing expected", {24'h0, m_tdata}, 32'h0);
        else
        begin
            want = expected_bytes.pop_front();
            if (m_tdata !== want.data_byte)
                report("data byte", {24'h0, m_tdata}, {24'h0, want.data_byte});
            if (m_tlast !== want.frame_done)
                report("frame done", {31'h0, m_tlast}, {31'h0, want.frame_done});
            if (m_tuser !== want.status)
                report("status", {30'h0, m_tuser}, {30'h0, want.status});
            byte_count++;
            if (want.status != sfs_pkg::ST_DATA)
                marker_count++;
            else if (want.frame_done)
                frame_count++;
        end
    endtask

    // watch both channels and the settings port
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_bytes.delete();
            crc_run           = sfs_pkg::CRC_INIT;
            cols_left         = 16'd0;
            in_frame          = 1'b0;
            set_decimation    = 16'd0;
            set_pretrigger    = 16'd0;
            set_posttrigger   = 16'd0;
            set_trigger_level = 16'd0;
            set_front_atten   = 8'd0;
            set_front_flags   = 8'd0;
            set_amp_atten     = 8'd0;
            set_offset_dac    = 16'd0;
            fail_count        = 0;
            frame_count       = 0;
            marker_count      = 0;
            byte_count        = 0;
            pending_count    <= 0;
        end
        else
        begin
            if (cfg_we)
                apply_setting(cfg_index, cfg_wdata);
            if (s_tvalid && s_tready)
                serialize_item(s_tuser[0], s_tdata);
            if (m_tvalid && m_tready)
                check_output();
            pending_count <= expected_bytes.size();
        end
    end

endmodule

// File: tb/tb_scope_frame_serializer_crc32_core.sv
// testbench top: drives frames and settings into the serializer and gives the verdict
module tb_scope_frame_serializer_crc32_core;

    localparam int RUN_LIMIT    = 1_000_000;
    localparam int DRAIN_CYCLES = 8;
    localparam int LONG_HOLD    = 400;
    localparam int PHASE_ITEMS  = 60;

    logic         clk;
    logic         rst_n;
    logic [167:0] s_tdata;
    logic [0:0]   s_tuser;
    logic         s_tvalid;
    logic         s_tready;
    logic [7:0]   m_tdata;
    logic [1:0]   m_tuser;
    logic         m_tlast;
    logic         m_tvalid;
    logic         m_tready;
    logic         cfg_we;
    logic [2:0]   cfg_index;
    logic [15:0]  cfg_wdata;

    int fail_count;
    int pending_count;
    int frame_count;
    int marker_count;
    int byte_count;

    int   tx_gap_max    = 16;
    int   rx_stall_max  = 16;
    logic hold_request  = 1'b0;
    int   items_sent    = 0;
    int   ignored_items = 0;
    int   cycle_count   = 0;

    scope_frame_serializer_crc32_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    scope_frame_checker frame_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .m_tlast       (m_tlast),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .fail_count    (fail_count),
        .pending_count (pending_count),
        .frame_count   (frame_count),
        .marker_count  (marker_count),
        .byte_count    (byte_count)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= RUN_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("TEST FAILED");
            $finish;
        end
    end

    // output side: random stalls per transaction, one long hold-off on request
    initial
    begin : rx_side
        int stall;
        m_tready <= 1'b0;
        @(posedge clk);
        while (rst_n !== 1'b1)
            @(posedge clk);
        forever
        begin
            if (hold_request)
            begin
                hold_request = 1'b0;
                stall = LONG_HOLD;
            end
            else
                stall = $urandom_range(rx_stall_max, 0);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid)
                @(posedge clk);
        end
    end

    // one input transaction after a random gap, held until accepted
    task automatic send_item(input logic start, input logic [15:0] count,
                             input logic [7:0] flags, input logic [31:0] seq,
                             input logic [31:0] samples, input logic [31:0] trig,
                             input logic [15:0] ovr, input logic [15:0] lo,
                             input logic [15:0] hi);
        int gap;
        gap = $urandom_range(tx_gap_max, 0);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= start;
        s_tdata  <= {hi, lo, ovr, trig, samples, seq, flags, count};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        items_sent++;
    endtask

    // column with random noise in the metadata fields
    task automatic send_column(input logic [15:0] lo, input logic [15:0] hi);
        send_item(1'b0, 16'($urandom_range(65535, 0)), 8'($urandom_range(255, 0)), $urandom(),
                  $urandom(), $urandom(), 16'($urandom_range(65535, 0)), lo, hi);
    endtask

    task automatic send_random_start(input logic [15:0] count);
        send_item(1'b1, count, 8'($urandom_range(255, 0)), $urandom(), $urandom(), $urandom(),
                  16'($urandom_range(65535, 0)), 16'($urandom_range(65535, 0)),
                  16'($urandom_range(65535, 0)));
    endtask

    task automatic stop_stream();
        s_tvalid <= 1'b0;
    endtask

    // wait until every expected byte has come and the pipeline has drained
    task automatic wait_idle();
        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] index, input logic [15:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_wdata <= value;
        @(posedge clk);
    endtask

    task automatic write_settings(input logic [15:0] dec, input logic [15:0] pre,
                                  input logic [15:0] post, input logic [15:0] level,
                                  input logic [7:0] f_atten, input logic [7:0] f_flags,
                                  input logic [7:0] a_atten, input logic [15:0] dac);
        write_reg(sfs_pkg::CFG_DECIMATION, dec);
        write_reg(sfs_pkg::CFG_PRETRIGGER_LEN, pre);
        write_reg(sfs_pkg::CFG_POSTTRIGGER_LEN, post);
        write_reg(sfs_pkg::CFG_TRIGGER_LEVEL, level);
        write_reg(sfs_pkg::CFG_FRONT_ATTEN, {8'h0, f_atten});
        write_reg(sfs_pkg::CFG_FRONT_FLAGS, {8'h0, f_flags});
        write_reg(sfs_pkg::CFG_AMP_ATTEN, {8'h0, a_atten});
        write_reg(sfs_pkg::CFG_OFFSET_DAC_CODE, dac);
        cfg_we <= 1'b0;
    endtask

    task automatic write_random_settings();
        write_settings(16'($urandom_range(65535, 0)), 16'($urandom_range(65535, 0)),
                       16'($urandom_range(65535, 0)), 16'($urandom_range(65535, 0)),
                       8'($urandom_range(255, 0)), 8'($urandom_range(255, 0)),
                       8'($urandom_range(255, 0)), 16'($urandom_range(65535, 0)));
    endtask

    // mostly complete frames with random content, plus zero counts, dropped frames
    // and stray columns
    task automatic run_random(input int n_items);
        int   stop_at;
        int   kind;
        int   cols;
        int   k;
        logic left_open;
        stop_at   = items_sent + n_items;
        left_open = 1'b0;
        while (items_sent - ignored_items < stop_at)
        begin
            kind = $urandom_range(99, 0);
            if (kind < 70)
            begin
                cols = ($urandom_range(9, 0) == 0) ? $urandom_range(40, 8)
                                                    : $urandom_range(5, 1);
                send_random_start(cols[15:0]);
                for (k = 1; k < cols; k++)
                    send_column(16'($urandom_range(65535, 0)), 16'($urandom_range(65535, 0)));
                left_open = 1'b0;
            end
            else if (kind < 80)
            begin
                send_random_start(16'd0);
                left_open = 1'b0;
            end
            else if (kind < 90)
            begin
                // frame that the next start cuts short
                send_random_start(16'($urandom_range(65535, 5)));
                cols = $urandom_range(3, 0);
                for (k = 0; k < cols; k++)
                    send_column(16'($urandom_range(65535, 0)), 16'($urandom_range(65535, 0)));
                left_open = 1'b1;
            end
            else
            begin
                send_column(16'($urandom_range(65535, 0)), 16'($urandom_range(65535, 0)));
                if (!left_open)
                    ignored_items++;
            end
        end
    endtask

    task automatic next_phase(input int gap_max, input int stall_max);
        stop_stream();
        wait_idle();
        tx_gap_max   = gap_max;
        rx_stall_max = stall_max;
    endtask

    // stimulus
    initial
    begin
        rst_n     <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tuser   <= 1'b0;
        s_tdata   <= '0;
        cfg_we    <= 1'b0;
        cfg_index <= sfs_pkg::CFG_DECIMATION;
        cfg_wdata <= 16'd0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // directed: all settings at their top values
        write_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF);
        send_column(16'hFFFF, 16'h0000);
        send_item(1'b1, 16'd1, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                  16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_item(1'b1, 16'd0, 8'h00, 32'h0, 32'h0, 32'h0, 16'h0, 16'h0, 16'h0);
        send_item(1'b1, 16'd3, 8'h00, 32'h0, 32'h0, 32'h0, 16'h0, 16'h0, 16'h0);
        send_column(16'h0000, 16'hFFFF);
        send_column(16'hFFFF, 16'h0000);
        // open frame with the largest count, aborted by the next start
        send_item(1'b1, 16'hFFFF, 8'hA5, 32'h8000_0001, 32'h5A5A_A5A5, 32'h0000_FFFF,
                  16'h8001, 16'h1234, 16'hFEDC);
        send_column(16'h00FF, 16'hFF00);
        send_random_start(16'd2);
        send_column(16'h7FFF, 16'h8000);
        // abort followed by a zero-count marker
        send_random_start(16'd4);
        send_random_start(16'd0);
        send_column(16'h5555, 16'hAAAA);
        send_random_start(16'h8000);
        send_random_start(16'd1);

        // all settings zero, no input gaps, one long output hold-off
        next_phase(0, 16);
        write_settings(16'h0, 16'h0, 16'h0, 16'h0, 8'h0, 8'h0, 8'h0, 16'h0);
        hold_request = 1'b1;
        run_random(PHASE_ITEMS);

        next_phase(16, 0);
        write_random_settings();
        run_random(PHASE_ITEMS);

        next_phase(0, 0);
        write_random_settings();
        run_random(PHASE_ITEMS);

        next_phase(16, 16);
        write_random_settings();
        run_random(PHASE_ITEMS);

        stop_stream();
        wait_idle();
        $display("covered %0d input transactions (%0d ignored columns) over five settings phases",
                 items_sent, ignored_items);
        $display("checked %0d output bytes: %0d frames with crc trailer, %0d markers",
                 byte_count, frame_count, marker_count);
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
